@@ hw/rtl/hwsp_pkg.sv @@
// hwsp_pkg: types, codes, constants and command/status structs for the slot picker
// no dependencies; imported by hwsp_ctrl, hwsp_dp and the top level
`default_nettype none

package hwsp_pkg;

    localparam int MAX_ENTRIES = 16;
    localparam int WEIGHT_W    = 16;
    localparam int HASH_W      = 64;
    localparam int HALF_W      = HASH_W / 2;
    localparam int OUT_IDX_W   = 4;
    localparam int IDX_W       = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
    localparam int CNT_W       = $clog2(MAX_ENTRIES + 1);
    localparam int TOT_W       = WEIGHT_W + $clog2(MAX_ENTRIES);
    localparam int DIV_CNT_W   = $clog2(HASH_W);
    localparam int MIX_SHIFT   = 33;

    localparam logic [HASH_W-1:0] K_GOLD = 64'h9e3779b97f4a7c15;
    localparam logic [HASH_W-1:0] K_MIX1 = 64'hff51afd7ed558ccd;
    localparam logic [HASH_W-1:0] K_MIX2 = 64'hc4ceb9fe1a85ec53;

    typedef enum logic [1:0] {
        ACT_CLEAR  = 2'd0,
        ACT_APPEND = 2'd1,
        ACT_PICK   = 2'd2
    } t_action;

    typedef enum logic [1:0] {
        ST_PICKED  = 2'd0,
        ST_EMPTY   = 2'd1,
        ST_DONE    = 2'd2,
        ST_DROPPED = 2'd3
    } t_status;

    typedef enum logic [1:0] {
        MC_GOLD,
        MC_MIX1,
        MC_MIX2
    } t_mconst;

    // which 32x32 partial product of the low 64-bit result
    typedef enum logic [1:0] {
        MP_LL,
        MP_LH,
        MP_HL
    } t_mpart;

    typedef enum logic [2:0] {
        S_IDLE,
        S_MUL,
        S_MIX,
        S_DIV,
        S_WALK_RD,
        S_WALK_ACC,
        S_OUT
    } t_state;

    typedef struct packed {
        logic    accept;
        logic    mul_go;
        t_mpart  mul_part;
        t_mconst mul_const;
        logic    acc_load;
        logic    acc_add;
        logic    mix;
        logic    mix_seed;
        logic    div_step;
        logic    walk_acc;
        logic    out_load;
    } t_cmd;

    typedef struct packed {
        logic start_pick;
        logic walk_hit;
        logic out_free;
    } t_sts;

endpackage

`default_nettype wire

@@ hw/rtl/hwsp_ram.sv @@
// hwsp_ram: generic single-write, single-read RAM with registered read data
// no dependencies
`default_nettype none

module hwsp_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 16,
    parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic              i_clk,
    input  wire logic              i_wr_en,
    input  wire logic [ADDR_W-1:0] i_wr_addr,
    input  wire logic [WIDTH-1:0]  i_wr_data,
    input  wire logic [ADDR_W-1:0] i_rd_addr,
    output logic      [WIDTH-1:0]  o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        o_rd_data <= r_mem[i_rd_addr];
    end

endmodule

`default_nettype wire

@@ hw/rtl/hwsp_ctrl.sv @@
// hwsp_ctrl: sequencer for accept, hash rounds, bit-serial modulo, table walk, result
// depends on hwsp_pkg
`default_nettype none

module hwsp_ctrl import hwsp_pkg::*; (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_in_valid,
    output logic      o_in_ready,
    input  wire t_sts i_sts,
    output t_cmd      o_cmd
);

    t_state               r_state, n_state;
    logic [1:0]           r_step, n_step;
    logic [1:0]           r_round, n_round;
    logic [DIV_CNT_W-1:0] r_div, n_div;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_step  <= '0;
            r_round <= '0;
            r_div   <= '0;
        end else begin
            r_state <= n_state;
            r_step  <= n_step;
            r_round <= n_round;
            r_div   <= n_div;
        end
    end

    always_comb begin
        n_state = r_state;
        n_step  = r_step;
        n_round = r_round;
        n_div   = r_div;
        o_cmd   = '0;
        o_in_ready = (r_state == S_IDLE);
        case (r_round)
            2'd0:    o_cmd.mul_const = MC_GOLD;
            2'd1:    o_cmd.mul_const = MC_MIX1;
            default: o_cmd.mul_const = MC_MIX2;
        endcase
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.accept = 1'b1;
                    n_step  = '0;
                    n_round = '0;
                    n_state = i_sts.start_pick ? S_MUL : S_OUT;
                end
            end
            S_MUL: begin
                // products issue on steps 0..2, each is accumulated in the step after it issues
                case (r_step)
                    2'd0: begin
                        o_cmd.mul_go   = 1'b1;
                        o_cmd.mul_part = MP_LL;
                    end
                    2'd1: begin
                        o_cmd.mul_go   = 1'b1;
                        o_cmd.mul_part = MP_LH;
                        o_cmd.acc_load = 1'b1;
                    end
                    2'd2: begin
                        o_cmd.mul_go   = 1'b1;
                        o_cmd.mul_part = MP_HL;
                        o_cmd.acc_add  = 1'b1;
                    end
                    default: begin
                        o_cmd.acc_add = 1'b1;
                    end
                endcase
                n_step = r_step + 2'd1;
                if (r_step == 2'd3) begin
                    n_state = S_MIX;
                end
            end
            S_MIX: begin
                o_cmd.mix      = 1'b1;
                o_cmd.mix_seed = (r_round == 2'd0);
                n_step  = '0;
                n_round = r_round + 2'd1;
                n_div   = '0;
                n_state = (r_round == 2'd2) ? S_DIV : S_MUL;
            end
            S_DIV: begin
                o_cmd.div_step = 1'b1;
                n_div = r_div + DIV_CNT_W'(1);
                if (r_div == DIV_CNT_W'(HASH_W - 1)) begin
                    n_state = S_WALK_RD;
                end
            end
            S_WALK_RD: begin
                n_state = S_WALK_ACC;
            end
            S_WALK_ACC: begin
                o_cmd.walk_acc = 1'b1;
                n_state = i_sts.walk_hit ? S_OUT : S_WALK_RD;
            end
            S_OUT: begin
                if (i_sts.out_free) begin
                    o_cmd.out_load = 1'b1;
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // a pick sequence always starts at round zero
    a_round_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_IDLE && i_in_valid && i_sts.start_pick)
        |=> (r_state == S_MUL && r_round == 2'd0 && r_step == 2'd0))
        else $error("pick did not start at first hash round");

    // the modulo runs its full length before the walk
    a_div_len: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_WALK_RD && $past(r_state) == S_DIV)
        |-> ($past(r_div) == DIV_CNT_W'(HASH_W - 1)))
        else $error("modulo left early");

    // no new request while the controller is busy
    a_no_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != S_IDLE) |-> !o_cmd.accept)
        else $error("request accepted while busy");

endmodule

`default_nettype wire

@@ hw/rtl/hwsp_dp.sv @@
// hwsp_dp: table state, seed, shared 32x32 multiplier, fmix, restoring modulo,
// cumulative walk and output register; depends on hwsp_pkg and hwsp_ram
`default_nettype none

module hwsp_dp import hwsp_pkg::*; (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire t_cmd                 i_cmd,
    output t_sts                      o_sts,
    input  wire logic [1:0]           i_action,
    input  wire logic [WEIGHT_W-1:0]  i_weight,
    input  wire logic [HASH_W-1:0]    i_slot,
    input  wire logic                 i_cfg_valid,
    input  wire logic [HASH_W-1:0]    i_seed,
    input  wire logic                 i_out_ready,
    output logic                      o_out_valid,
    output logic [1:0]                o_status,
    output logic [OUT_IDX_W-1:0]      o_picked_index
);

    logic [HASH_W-1:0]    r_seed;
    logic [CNT_W-1:0]     r_count;
    logic [TOT_W-1:0]     r_total;
    logic [HASH_W-1:0]    r_x;
    logic [HASH_W-1:0]    r_prod;
    logic [HASH_W-1:0]    r_acc;
    logic [TOT_W-1:0]     r_rem;
    logic [IDX_W-1:0]     r_widx;
    logic [TOT_W-1:0]     r_wacc;
    t_status              r_res_status;
    logic [OUT_IDX_W-1:0] r_res_index;
    logic                 r_out_valid;
    t_status              r_out_status;
    logic [OUT_IDX_W-1:0] r_out_index;

    logic [WEIGHT_W-1:0] in_eff;
    logic [WEIGHT_W-1:0] rd_data;
    logic [WEIGHT_W-1:0] rd_eff;
    logic                app_ok;
    logic [HASH_W-1:0]   k_sel;
    logic [HALF_W-1:0]   mul_a;
    logic [HALF_W-1:0]   mul_b;
    logic [HASH_W-1:0]   mix_t;
    logic [TOT_W:0]      div_t;
    logic [TOT_W:0]      tot_ext;
    logic [TOT_W-1:0]    tot;
    logic [TOT_W-1:0]    walk_sum;
    logic                walk_last;

    assign in_eff  = (i_weight == '0) ? WEIGHT_W'(1) : i_weight;
    assign rd_eff  = (rd_data == '0) ? WEIGHT_W'(1) : rd_data;
    assign app_ok  = (r_count < CNT_W'(MAX_ENTRIES));
    assign tot     = (r_total == '0) ? TOT_W'(1) : r_total;
    assign tot_ext = {1'b0, tot};

    hwsp_ram #(
        .WIDTH (WEIGHT_W),
        .DEPTH (MAX_ENTRIES)
    ) u_table (
        .i_clk     (i_clk),
        .i_wr_en   (i_cmd.accept && i_action == ACT_APPEND && app_ok),
        .i_wr_addr (r_count[IDX_W-1:0]),
        .i_wr_data (i_weight),
        .i_rd_addr (r_widx),
        .o_rd_data (rd_data)
    );

    always_comb begin
        case (i_cmd.mul_const)
            MC_GOLD: k_sel = K_GOLD;
            MC_MIX1: k_sel = K_MIX1;
            default: k_sel = K_MIX2;
        endcase
        mul_a = (i_cmd.mul_part == MP_HL) ? r_x[HASH_W-1:HALF_W] : r_x[HALF_W-1:0];
        mul_b = (i_cmd.mul_part == MP_LH) ? k_sel[HASH_W-1:HALF_W] : k_sel[HALF_W-1:0];
    end

    assign mix_t     = i_cmd.mix_seed ? (r_acc ^ r_seed) : r_acc;
    assign div_t     = {r_rem, r_x[HASH_W-1]};
    assign walk_sum  = r_wacc + TOT_W'(rd_eff);
    assign walk_last = (CNT_W'(r_widx) == r_count - CNT_W'(1));

    always_comb begin
        o_sts.start_pick = (i_action == ACT_PICK) && (r_count != '0);
        o_sts.walk_hit   = (r_rem < walk_sum) || walk_last;
        o_sts.out_free   = !r_out_valid || i_out_ready;
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_seed      <= '0;
            r_count     <= '0;
            r_total     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_valid) begin
                r_seed <= i_seed;
            end
            if (i_cmd.accept) begin
                case (i_action)
                    ACT_CLEAR: begin
                        r_count <= '0;
                        r_total <= '0;
                    end
                    ACT_APPEND: begin
                        if (app_ok) begin
                            r_count <= r_count + CNT_W'(1);
                            r_total <= r_total + TOT_W'(in_eff);
                        end
                    end
                    default: begin
                    end
                endcase
            end
            if (i_cmd.out_load) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // payload
    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_x    <= i_slot;
            r_rem  <= '0;
            r_widx <= '0;
            r_wacc <= '0;
            r_res_index <= '0;
            case (i_action)
                ACT_CLEAR:  r_res_status <= ST_DONE;
                ACT_APPEND: r_res_status <= app_ok ? ST_DONE : ST_DROPPED;
                ACT_PICK:   r_res_status <= (r_count == '0) ? ST_EMPTY : ST_PICKED;
                default:    r_res_status <= ST_DROPPED;
            endcase
        end
        if (i_cmd.mul_go) begin
            r_prod <= HASH_W'(mul_a) * HASH_W'(mul_b);
        end
        if (i_cmd.acc_load) begin
            r_acc <= r_prod;
        end else if (i_cmd.acc_add) begin
            r_acc <= r_acc + {r_prod[HALF_W-1:0], {HALF_W{1'b0}}};
        end
        if (i_cmd.mix) begin
            r_x <= mix_t ^ (mix_t >> MIX_SHIFT);
        end
        if (i_cmd.div_step) begin
            // restoring step, one hash bit per cycle from the top
            r_x <= {r_x[HASH_W-2:0], 1'b0};
            if (div_t >= tot_ext) begin
                r_rem <= TOT_W'(div_t - tot_ext);
            end else begin
                r_rem <= div_t[TOT_W-1:0];
            end
        end
        if (i_cmd.walk_acc) begin
            r_wacc <= walk_sum;
            if (o_sts.walk_hit) begin
                r_res_status <= ST_PICKED;
                r_res_index  <= OUT_IDX_W'(r_widx);
            end else begin
                r_widx <= r_widx + IDX_W'(1);
            end
        end
        if (i_cmd.out_load) begin
            r_out_status <= r_res_status;
            r_out_index  <= r_res_index;
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_status       = r_out_status;
    assign o_picked_index = r_out_index;

    // every effective weight is at least one
    a_total_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_count == '0) == (r_total == '0))
        else $error("total weight and entry count disagree");

    a_count_max: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.accept && i_action == ACT_APPEND && !app_ok) |=> $stable(r_count))
        else $error("append to full table changed the count");

    // pick value below total, so the walk never passes the end
    a_rem_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.walk_acc |-> (r_rem < tot))
        else $error("pick value not below total");

    a_out_load_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.out_load |-> o_sts.out_free)
        else $error("result overwritten before taken");

endmodule

`default_nettype wire

@@ hw/rtl/hashed_weighted_slot_picker.sv @@
// hashed_weighted_slot_picker: top level, controller plus datapath
// depends on hwsp_pkg, hwsp_ctrl, hwsp_dp, hwsp_ram
//
//  channel   handshake                    payload
//  input     i_in_valid / o_in_ready      i_action, i_weight, i_slot
//  result    o_out_valid / i_out_ready    o_status, o_picked_index
//  config    i_cfg_valid / o_cfg_ready    i_seed
//
// clear, append and an empty pick pass from accept through the output state to the
// result register; a pick walks k entries (1..16) after three 64-bit multiplies on
// one shared 32x32 multiplier (partial products, then a mix, for each), a restoring
// modulo over the hash bits and a read-then-add walk of the registered table RAM
// one request at a time; the result register lets the next request in while
// the last result waits; reset is synchronous, no clearing pass is needed
`default_nettype none

module hashed_weighted_slot_picker import hwsp_pkg::*; (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_in_valid,
    output logic                      o_in_ready,
    input  wire logic [1:0]           i_action,
    input  wire logic [WEIGHT_W-1:0]  i_weight,
    input  wire logic [HASH_W-1:0]    i_slot,
    output logic                      o_out_valid,
    input  wire logic                 i_out_ready,
    output logic [1:0]                o_status,
    output logic [OUT_IDX_W-1:0]      o_picked_index,
    input  wire logic                 i_cfg_valid,
    output logic                      o_cfg_ready,
    input  wire logic [HASH_W-1:0]    i_seed
);

    t_cmd cmd;
    t_sts sts;

    assign o_cfg_ready = 1'b1;

    hwsp_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_sts      (sts),
        .o_cmd      (cmd)
    );

    hwsp_dp u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (cmd),
        .o_sts          (sts),
        .i_action       (i_action),
        .i_weight       (i_weight),
        .i_slot         (i_slot),
        .i_cfg_valid    (i_cfg_valid),
        .i_seed         (i_seed),
        .i_out_ready    (i_out_ready),
        .o_out_valid    (o_out_valid),
        .o_status       (o_status),
        .o_picked_index (o_picked_index)
    );

endmodule

`default_nettype wire
